@@ rtl/divider_and_programmable_timer_unit_defines.svh @@
// Assertion macros for the checker file.
`ifndef DIVIDER_AND_PROGRAMMABLE_TIMER_UNIT_DEFINES_SVH
`define DIVIDER_AND_PROGRAMMABLE_TIMER_UNIT_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define DPTU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DPTU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/dptu_pkg.sv @@
`default_nettype none

package dptu_pkg;

   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 16;

   localparam logic [1:0] FUNC_ADVANCE  = 2'd0;
   localparam logic [1:0] FUNC_READ     = 2'd1;
   localparam logic [1:0] FUNC_WRITE    = 2'd2;
   // Unassigned code; it only advances time.
   localparam logic [1:0] FUNC_RESERVED = 2'd3;

   typedef enum logic [1:0] {
      SEL_DIVIDER = 2'd0,
      SEL_COUNTER = 2'd1,
      SEL_MODULO  = 2'd2,
      SEL_CONTROL = 2'd3
   } sel_type;

   localparam logic [4:0] CYCLE_CAP       = 5'd16;
   localparam int         ENABLE_BIT      = 2;
   localparam logic [7:0] COUNT_MAX       = 8'hFF;
   localparam logic [10:0] PERIOD_RESET   = 11'd1024;

   typedef struct packed {
      logic [1:0] func;
      sel_type    reg_sel;
      logic [7:0] write_data;
      logic [4:0] cycles;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       timer_irq;
   } result_type;

   // Timer period selected by the two low control bits.
   function automatic logic [10:0] period_of(input logic [1:0] rate);
      logic [10:0] p;
      unique case (rate)
         2'd0:    p = 11'd1024;
         2'd1:    p = 11'd16;
         2'd2:    p = 11'd64;
         default: p = 11'd256;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

@@ rtl/dptu_req_stage.sv @@
`default_nettype none

module dptu_req_stage
   import dptu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // write_data [7:0], cycles [12:8], zero fill above
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // func [1:0], reg_sel [3:2]
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   input  wire logic                   take,
   output logic                        item_valid,
   output item_type                    item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   // The held transaction leaves in the same cycle that a new one arrives.
   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         item_in.func       = req_tuser[1:0];
         item_in.reg_sel    = sel_type'(req_tuser[3:2]);
         item_in.write_data = req_tdata[7:0];
         item_in.cycles     = req_tdata[12:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

@@ rtl/dptu_core.sv @@
`default_nettype none

module dptu_core
   import dptu_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     take,
   input  wire item_type item,
   output result_type    result
);

   logic [7:0]  div_ff, div_in;
   logic [7:0]  sub_ff, sub_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  modulo_ff, modulo_in;
   logic [7:0]  control_ff, control_in;
   logic [10:0] period_ff, period_in;

   always_comb begin
      logic [4:0]  cyc;
      logic [8:0]  sub_sum;
      logic [11:0] left;
      logic [11:0] reload;
      logic        tick;
      logic        irq;
      logic [7:0]  rd;

      cyc     = (item.cycles > CYCLE_CAP) ? CYCLE_CAP : item.cycles;
      sub_sum = {1'b0, sub_ff} + {4'b0, cyc};
      sub_in  = sub_sum[7:0];
      div_in  = div_ff + {7'b0, sub_sum[8]};

      // The period count runs only while enabled; zero or below means a tick.
      left   = {1'b0, period_ff} - {7'b0, cyc};
      reload = left + {1'b0, period_of(control_ff[1:0])};
      tick   = control_ff[ENABLE_BIT] && (left[11] || (left == 12'd0));
      irq    = tick && (count_ff == COUNT_MAX);

      period_in  = period_ff;
      if (control_ff[ENABLE_BIT]) begin
         period_in = tick ? reload[10:0] : left[10:0];
      end

      count_in = count_ff;
      if (irq) begin
         count_in = modulo_ff;
      end else if (tick) begin
         count_in = count_ff + 8'd1;
      end

      modulo_in  = modulo_ff;
      control_in = control_ff;
      rd         = 8'd0;

      // Register access sees the state after the time advance.
      if (item.func == FUNC_READ) begin
         unique case (item.reg_sel)
            SEL_DIVIDER: rd = div_in;
            SEL_COUNTER: rd = count_in;
            SEL_MODULO:  rd = modulo_ff;
            SEL_CONTROL: rd = control_ff;
            default:     rd = 8'd0;
         endcase
      end else if (item.func == FUNC_WRITE) begin
         unique case (item.reg_sel)
            SEL_DIVIDER: div_in = 8'd0;
            SEL_COUNTER: count_in = item.write_data;
            SEL_MODULO:  modulo_in = item.write_data;
            SEL_CONTROL: begin
               control_in = item.write_data;
               period_in  = period_of(item.write_data[1:0]);
            end
            default: ;
         endcase
      end

      result.read_data = rd;
      result.timer_irq = irq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff     <= 8'd0;
         sub_ff     <= 8'd0;
         count_ff   <= 8'd0;
         modulo_ff  <= 8'd0;
         control_ff <= 8'd0;
         period_ff  <= PERIOD_RESET;
      end else if (take) begin
         div_ff     <= div_in;
         sub_ff     <= sub_in;
         count_ff   <= count_in;
         modulo_ff  <= modulo_in;
         control_ff <= control_in;
         period_ff  <= period_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/divider_and_programmable_timer_unit.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  req_tdata, req_tuser
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata
//
// One transaction per clock cycle sustained while responses are taken; each one is answered
// by exactly one response, passing through the input register and then the result
// register around the single pass of timer logic.
// Reset is synchronous and returns all timer registers to their power-up values.
// A stalled response holds the result register; the held request then waits, and a
// new request is taken only while the input register is empty or being emptied.
`default_nettype none

module divider_and_programmable_timer_unit
   import dptu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // write_data [7:0], cycles [12:8], zero fill above
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // func [1:0], reg_sel [3:2]
   input  wire logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // read_data [7:0], timer_irq [8], zero fill above
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   logic       item_valid;
   item_type   item;
   result_type result;
   logic       take;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   assign take = item_valid && (!rsp_valid_ff || rsp_tready);

   dptu_req_stage u_req_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   dptu_core u_core (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .item   (item),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 9){1'b0}}, rsp_ff.timer_irq, rsp_ff.read_data};

endmodule

`default_nettype wire

@@ rtl/dptu_checker.sv @@
`default_nettype none
`include "divider_and_programmable_timer_unit_defines.svh"

module dptu_checker
   import dptu_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // A response that is not taken stays offered.
   `DPTU_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "response dropped while stalled")

   // A stalled response keeps its payload.
   `DPTU_ASSERT(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata), "stalled response changed")

   // Reset leaves no response pending.
   `DPTU_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "response pending after reset")

   // With the result register empty, nothing may hold back a request.
   `DPTU_ASSERT(a_ready_when_empty, !rsp_tvalid |-> req_tready, "request blocked with empty output")

endmodule

bind divider_and_programmable_timer_unit dptu_checker u_dptu_checker (.*);

`default_nettype wire

@@ bench/tb_divider_and_programmable_timer_unit.sv @@
`timescale 1ns / 1ps

module tb_divider_and_programmable_timer_unit;
   import dptu_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 1850;
   localparam logic [10:0] RATE_PERIOD [4] = '{11'd1024, 11'd16, 11'd64, 11'd256};

   typedef struct {
      item_type it;
      bit       drain;
   } pending_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // write_data [7:0], cycles [12:8], zero fill above
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // func [1:0], reg_sel [3:2]
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // read_data [7:0], timer_irq [8], zero fill above
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Timer state as seen by the predictor.
   logic [7:0]  div_count;
   logic [7:0]  div_sub;
   logic [7:0]  timer_count;
   logic [7:0]  timer_modulo;
   logic [7:0]  timer_ctrl;
   logic [10:0] period_left;

   pending_type pending_q[$];
   result_type  expected_q[$];
   pending_type next_entry;
   item_type    taken_item;
   result_type  want;

   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit req_busy = 1'b0;
   bit rsp_busy = 1'b0;
   int req_gap = 0;
   int rsp_stall = 0;
   int total_items = 0;
   int accepted_items = 0;
   int error_count = 0;
   int idle_cycles = 0;

   divider_and_programmable_timer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void reset_timer_model();
      div_count    = '0;
      div_sub      = '0;
      timer_count  = '0;
      timer_modulo = '0;
      timer_ctrl   = '0;
      period_left  = PERIOD_RESET;
   endfunction

   // Advances time first, then applies the register access.
   function automatic result_type timer_step(input item_type it);
      result_type res;
      logic [4:0] cyc;
      logic [8:0] sub;
      int         left;
      res = '0;
      cyc = (it.cycles > CYCLE_CAP) ? CYCLE_CAP : it.cycles;
      sub = {1'b0, div_sub} + 9'(cyc);
      if (sub >= 9'd256) begin
         div_count = div_count + 8'd1;
         sub = sub - 9'd256;
      end
      div_sub = sub[7:0];
      if (timer_ctrl[ENABLE_BIT]) begin
         left = int'(period_left) - int'(cyc);
         if (left <= 0) begin
            left = left + int'(RATE_PERIOD[timer_ctrl[1:0]]);
            if (timer_count == COUNT_MAX) begin
               timer_count = timer_modulo;
               res.timer_irq = 1'b1;
            end else begin
               timer_count = timer_count + 8'd1;
            end
         end
         period_left = 11'(left);
      end
      case (it.func)
         FUNC_READ: begin
            case (it.reg_sel)
               SEL_DIVIDER: res.read_data = div_count;
               SEL_COUNTER: res.read_data = timer_count;
               SEL_MODULO:  res.read_data = timer_modulo;
               default:     res.read_data = timer_ctrl;
            endcase
         end
         FUNC_WRITE: begin
            case (it.reg_sel)
               SEL_DIVIDER: div_count = '0;
               SEL_COUNTER: timer_count = it.write_data;
               SEL_MODULO:  timer_modulo = it.write_data;
               default: begin
                  timer_ctrl  = it.write_data;
                  period_left = RATE_PERIOD[it.write_data[1:0]];
               end
            endcase
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int want_val, input int got_val);
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want_val,
               got_val);
      error_count++;
   endtask

   task automatic queue_item(input logic [1:0] func, input sel_type sel,
                             input logic [7:0] data, input logic [4:0] cyc,
                             input bit drain = 1'b0);
      pending_type p;
      p.it.func       = func;
      p.it.reg_sel    = sel;
      p.it.write_data = data;
      p.it.cycles     = cyc;
      p.drain         = drain;
      pending_q.push_back(p);
   endtask

   // Mostly legal cycle counts, with some above the saturation point.
   function automatic logic [4:0] pick_cycles();
      int r;
      r = $urandom_range(0, 9);
      if (r <= 5) return 5'($urandom_range(0, 16));
      if (r <= 7) return 5'd4;
      if (r == 8) return 5'd16;
      return 5'($urandom_range(17, 31));
   endfunction

   task automatic build_stimulus();
      int          r;
      logic [7:0]  data;
      // Directed opening: reset values, overflow, write after overflow, saturation.
      queue_item(FUNC_READ, SEL_CONTROL, 8'h00, 5'd0);
      queue_item(FUNC_READ, SEL_COUNTER, 8'h00, 5'd0);
      queue_item(FUNC_WRITE, SEL_CONTROL, 8'h05, 5'd4);
      queue_item(FUNC_WRITE, SEL_MODULO, 8'hAB, 5'd4);
      queue_item(FUNC_WRITE, SEL_COUNTER, 8'hFF, 5'd0);
      queue_item(FUNC_ADVANCE, SEL_DIVIDER, 8'h00, 5'd16);
      queue_item(FUNC_READ, SEL_COUNTER, 8'h00, 5'd31);
      queue_item(FUNC_WRITE, SEL_COUNTER, 8'hFF, 5'd16);
      queue_item(FUNC_WRITE, SEL_COUNTER, 8'h55, 5'd16);
      queue_item(FUNC_READ, SEL_COUNTER, 8'h00, 5'd17);
      queue_item(FUNC_RESERVED, SEL_CONTROL, 8'hFF, 5'd31);
      queue_item(FUNC_READ, SEL_DIVIDER, 8'h00, 5'd16);
      queue_item(FUNC_WRITE, SEL_DIVIDER, 8'hFF, 5'd16);
      queue_item(FUNC_READ, SEL_DIVIDER, 8'h00, 5'd0, 1'b1);
      queue_item(FUNC_WRITE, SEL_CONTROL, 8'hFF, 5'd16);
      queue_item(FUNC_READ, SEL_CONTROL, 8'h00, 5'd16);
      queue_item(FUNC_WRITE, SEL_CONTROL, 8'h06, 5'd8);
      queue_item(FUNC_WRITE, SEL_CONTROL, 8'h00, 5'd16);
      queue_item(FUNC_ADVANCE, SEL_DIVIDER, 8'h00, 5'd16);
      queue_item(FUNC_READ, SEL_COUNTER, 8'hAA, 5'd16);
      queue_item(FUNC_WRITE, SEL_MODULO, 8'h00, 5'd1);
      queue_item(FUNC_WRITE, SEL_CONTROL, 8'h04, 5'd16);
      queue_item(FUNC_READ, SEL_MODULO, 8'h00, 5'd15);
      queue_item(FUNC_WRITE, SEL_CONTROL, 8'hFB, 5'd16);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(0, 99);
         data = 8'($urandom_range(0, 255));
         if (r < 10) begin
            // Keep the timer running most of the time.
            if ($urandom_range(0, 3) != 0) data[ENABLE_BIT] = 1'b1;
            queue_item(FUNC_WRITE, SEL_CONTROL, data, pick_cycles(),
                       $urandom_range(0, 299) == 0);
         end else if (r < 20) begin
            if ($urandom_range(0, 2) != 0) data = 8'($urandom_range(8'hFC, 8'hFF));
            queue_item(FUNC_WRITE, SEL_COUNTER, data, pick_cycles());
         end else if (r < 28) begin
            queue_item(FUNC_WRITE, SEL_MODULO, data, pick_cycles());
         end else if (r < 32) begin
            queue_item(FUNC_WRITE, SEL_DIVIDER, data, pick_cycles());
         end else if (r < 60) begin
            queue_item(FUNC_READ, sel_type'($urandom_range(0, 3)), data, pick_cycles());
         end else if (r < 95) begin
            queue_item(($urandom_range(0, 9) == 0) ? FUNC_RESERVED : FUNC_ADVANCE,
                       sel_type'($urandom_range(0, 3)), data, pick_cycles());
         end else begin
            queue_item(2'($urandom_range(0, 3)), sel_type'($urandom_range(0, 3)), data,
                       5'($urandom_range(0, 31)));
         end
      end
      total_items = pending_q.size();
   endtask

   // Request driver: one transaction at a time, random gaps between them in busy phases.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // Transaction still waiting for the handshake.
      end else if (req_gap > 0) begin
         req_tvalid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_q.size() == 0 || (pending_q[0].drain && expected_q.size() != 0)) begin
         req_tvalid <= 1'b0;
      end else begin
         next_entry = pending_q.pop_front();
         req_tdata  <= {3'b000, next_entry.it.cycles, next_entry.it.write_data};
         req_tuser  <= {next_entry.it.reg_sel, next_entry.it.func};
         req_tvalid <= 1'b1;
         if ($urandom_range(0, 49) == 0) req_busy = !req_busy;
         req_gap <= req_busy ? $urandom_range(0, 6) : 0;
      end
   end

   // Response side back-pressure.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_taken) begin
         if ($urandom_range(0, 49) == 0) rsp_busy = !rsp_busy;
         if (rsp_busy && $urandom_range(0, 1) == 1) begin
            rsp_tready <= 1'b0;
            rsp_stall <= $urandom_range(0, 5);
         end else begin
            rsp_tready <= 1'b1;
         end
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts on each accepted request and checks each accepted response.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         rsp_taken <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) begin
            taken_item.write_data = req_tdata[7:0];
            taken_item.cycles     = req_tdata[12:8];
            taken_item.func       = req_tuser[1:0];
            taken_item.reg_sel    = sel_type'(req_tuser[3:2]);
            expected_q.push_back(timer_step(taken_item));
            accepted_items++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected response", 0, rsp_tdata);
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[7:0] !== want.read_data)
                  report_mismatch("read_data", want.read_data, rsp_tdata[7:0]);
               if (rsp_tdata[8] !== want.timer_irq)
                  report_mismatch("timer_irq", want.timer_irq, rsp_tdata[8]);
            end
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_divider_and_programmable_timer_unit: FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      reset_timer_model();
      build_stimulus();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (accepted_items < total_items || expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_divider_and_programmable_timer_unit: PASS");
      end else begin
         $display("tb_divider_and_programmable_timer_unit: FAIL");
      end
      $finish;
   end

endmodule
